@@ hdl/srarq_pkg.sv @@
// shared types and constants for the selective repeat arq sender
// no dependencies; compiled first
package srarq_pkg;

  localparam int FRAME_W        = 10;
  localparam int FRAME_MAX      = 1023;
  localparam int KIND_W         = 3;
  localparam int WIN_W          = 6;
  localparam int CREDIT_W       = 7;
  localparam int CREDIT_MAX     = 127;
  localparam int ACK_W          = 11;
  localparam int MAX_RES        = 32;
  localparam int RES_CNT_W      = 6;
  localparam int MAX_FRAMES_DEF = 1024;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 10;

  // event kinds
  localparam logic [KIND_W-1:0] KIND_START   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ACK     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_NACK    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_TIMEOUT = 3'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LAST_FRAME  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_WINDOW = 1'd1;

  // result request from the sequencer to the output stage
  typedef struct packed {
    logic               push;
    logic               flush;
    logic [FRAME_W-1:0] idx;
    logic               done;
  } emit_req_t;

endpackage

@@ hdl/srarq_if.sv @@
// channel interfaces: event input, result output and configuration write
// depends on srarq_pkg
interface srarq_in_if;
  import srarq_pkg::*;
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [FRAME_W-1:0] frame_index;
  modport source (output valid, kind, frame_index, input ready);
  modport sink (input valid, kind, frame_index, output ready);
endinterface

interface srarq_out_if;
  import srarq_pkg::*;
  logic               valid;
  logic               ready;
  logic [FRAME_W-1:0] send_index;
  logic               done_res;
  logic               last;
  modport source (output valid, send_index, done_res, last, input ready);
  modport sink (input valid, send_index, done_res, last, output ready);
endinterface

interface srarq_cfg_if;
  import srarq_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ hdl/srarq_mark_mem.sv @@
// acknowledged-mark bitmap, one bit per frame, one read and one write port
// no package dependency; read data is registered
module srarq_mark_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic          rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic          wr_data
);

  logic mem [DEPTH];
  logic rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hdl/srarq_out_stage.sv @@
// result output stage: one held result plus the output register,
// so the last flag can be set when the sequencer closes a request
// depends on srarq_pkg
module srarq_out_stage (
  input  logic                        clk,
  input  logic                        rst_n,
  input  srarq_pkg::emit_req_t        req,
  output logic                        req_ready,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [srarq_pkg::FRAME_W-1:0] out_send_index,
  output logic                        out_done_res,
  output logic                        out_last
);
  import srarq_pkg::*;

  logic               hold_v_r, hold_v_nxt;
  logic [FRAME_W-1:0] hold_idx_r;
  logic               hold_done_r;
  logic               out_v_r, out_v_nxt;
  logic [FRAME_W-1:0] out_idx_r;
  logic               out_done_r;
  logic               out_last_r;
  logic               out_free;
  logic               acc_ok;
  logic               move;

  always_comb begin
    out_free   = !out_v_r || out_ready;
    acc_ok     = !hold_v_r || out_free;
    move       = (req.push || req.flush) && acc_ok && hold_v_r;
    hold_v_nxt = hold_v_r;
    out_v_nxt  = out_v_r;
    if (req.push && acc_ok) begin
      hold_v_nxt = 1'b1;
    end else if (req.flush && acc_ok) begin
      hold_v_nxt = 1'b0;
    end
    if (move) begin
      out_v_nxt = 1'b1;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      hold_v_r <= hold_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.push && acc_ok) begin
      hold_idx_r  <= req.idx;
      hold_done_r <= req.done;
    end
    if (move) begin
      out_idx_r  <= hold_idx_r;
      out_done_r <= hold_done_r;
      out_last_r <= req.flush;
    end
  end

  assign req_ready      = acc_ok;
  assign out_valid      = out_v_r;
  assign out_send_index = out_idx_r;
  assign out_done_res   = out_done_r;
  assign out_last       = out_last_r;

endmodule

@@ hdl/srarq_seq.sv @@
// event sequencer: decodes one request, scans the mark bitmap one frame
// at a time, reading then checking each, and issues results; depends on srarq_pkg
module srarq_seq #(
  parameter int MAX_FRAMES = srarq_pkg::MAX_FRAMES_DEF,
  parameter int AW         = $clog2(MAX_FRAMES)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [srarq_pkg::KIND_W-1:0]  in_kind,
  input  logic [srarq_pkg::FRAME_W-1:0] in_frame_index,
  input  logic [srarq_pkg::FRAME_W-1:0] cfg_last_frame,
  input  logic [srarq_pkg::WIN_W-1:0]   cfg_init_window,
  output logic                          mem_rd_en,
  output logic [AW-1:0]                 mem_rd_addr,
  input  logic                          mem_rd_data,
  output logic                          mem_wr_en,
  output logic [AW-1:0]                 mem_wr_addr,
  output logic                          mem_wr_data,
  output srarq_pkg::emit_req_t          emit_req,
  input  logic                          emit_ready
);
  import srarq_pkg::*;

  localparam logic [FRAME_W-1:0] LF_LIM = (MAX_FRAMES - 1 < FRAME_MAX) ?
    FRAME_W'(MAX_FRAMES - 1) : FRAME_W'(FRAME_MAX);
  localparam logic [AW-1:0] CLR_LAST = AW'(MAX_FRAMES - 1);

  typedef enum logic [11:0] {
    S_CLEAR    = 12'b0000_0000_0001,
    S_IDLE     = 12'b0000_0000_0010,
    S_DISPATCH = 12'b0000_0000_0100,
    S_ACK_RD   = 12'b0000_0000_1000,
    S_ACK_CHK  = 12'b0000_0001_0000,
    S_CREDIT   = 12'b0000_0010_0000,
    S_BURST    = 12'b0000_0100_0000,
    S_SCAN_RD  = 12'b0000_1000_0000,
    S_SCAN_CHK = 12'b0001_0000_0000,
    S_EMIT     = 12'b0010_0000_0000,
    S_TAIL     = 12'b0100_0000_0000,
    S_FLUSH    = 12'b1000_0000_0000
  } state_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_RUN  = 3'b010,
    PH_DONE = 3'b100
  } phase_t;

  state_t                state_r, state_nxt;
  state_t                ret_r, ret_nxt;
  phase_t                phase_r, phase_nxt;
  logic [AW-1:0]         clr_cnt_r, clr_cnt_nxt;
  logic [FRAME_W-1:0]    sp_r, sp_nxt;
  logic [CREDIT_W-1:0]   credit_r, credit_nxt;
  logic [ACK_W-1:0]      ack_total_r, ack_total_nxt;
  logic [RES_CNT_W-1:0]  n_r, n_nxt;
  logic                  scan_burst_r, scan_burst_nxt;
  logic [KIND_W-1:0]     kind_r, kind_nxt;
  logic [FRAME_W-1:0]    idx_r, idx_nxt;
  logic [FRAME_W-1:0]    lf_r, lf_nxt;
  logic [FRAME_W-1:0]    scan_p_r, scan_p_nxt;
  logic [FRAME_W-1:0]    scan_cnt_r, scan_cnt_nxt;
  logic [FRAME_W-1:0]    em_idx_r, em_idx_nxt;
  logic                  em_done_r, em_done_nxt;

  logic [FRAME_W-1:0]    lf_eff;
  logic [FRAME_W:0]      p_inc;
  logic [FRAME_W-1:0]    p_next;
  logic [FRAME_W-1:0]    w_min;
  logic [FRAME_W-1:0]    w_clamp;
  logic [CREDIT_W-1:0]   credit_inc;
  logic                  res_room;

  function automatic logic [CREDIT_W-1:0] sat_inc(input logic [CREDIT_W-1:0] c);
    logic [CREDIT_W-1:0] r;
    r = (c == CREDIT_W'(CREDIT_MAX)) ? c : c + 1'b1;
    return r;
  endfunction

  always_comb begin
    lf_eff     = (cfg_last_frame > LF_LIM) ? LF_LIM : cfg_last_frame;
    p_inc      = {1'b0, scan_p_r} + 1'b1;
    // wrap to frame 0 past the last frame
    p_next     = (p_inc > {1'b0, lf_r}) ? '0 : p_inc[FRAME_W-1:0];
    w_min      = (FRAME_W'(cfg_init_window) < lf_r) ? FRAME_W'(cfg_init_window) : lf_r;
    w_clamp    = (w_min == '0) ? FRAME_W'(1) :
                 (w_min > FRAME_W'(MAX_RES)) ? FRAME_W'(MAX_RES) : w_min;
    credit_inc = sat_inc(credit_r);
    res_room   = n_r < RES_CNT_W'(MAX_RES);

    state_nxt      = state_r;
    ret_nxt        = ret_r;
    phase_nxt      = phase_r;
    clr_cnt_nxt    = clr_cnt_r;
    sp_nxt         = sp_r;
    credit_nxt     = credit_r;
    ack_total_nxt  = ack_total_r;
    n_nxt          = n_r;
    scan_burst_nxt = scan_burst_r;
    kind_nxt       = kind_r;
    idx_nxt        = idx_r;
    lf_nxt         = lf_r;
    scan_p_nxt     = scan_p_r;
    scan_cnt_nxt   = scan_cnt_r;
    em_idx_nxt     = em_idx_r;
    em_done_nxt    = em_done_r;

    in_ready       = 1'b0;
    mem_rd_en      = 1'b0;
    mem_rd_addr    = AW'(idx_r);
    mem_wr_en      = 1'b0;
    mem_wr_addr    = clr_cnt_r;
    mem_wr_data    = 1'b0;
    emit_req       = '{push: 1'b0, flush: 1'b0, idx: em_idx_r, done: em_done_r};

    case (state_r)
      S_CLEAR: begin
        mem_wr_en   = 1'b1;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == CLR_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          kind_nxt  = in_kind;
          idx_nxt   = in_frame_index;
          lf_nxt    = lf_eff;
          n_nxt     = '0;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_nxt = S_FLUSH;
        if (phase_r == PH_DONE) begin
          em_idx_nxt  = '0;
          em_done_nxt = 1'b1;
          ret_nxt     = S_FLUSH;
          state_nxt   = S_EMIT;
        end else if (phase_r == PH_IDLE) begin
          if (kind_r == KIND_START) begin
            phase_nxt     = PH_RUN;
            sp_nxt        = '0;
            ack_total_nxt = '0;
            credit_nxt    = CREDIT_W'(w_clamp - 1'b1);
            em_idx_nxt    = '0;
            em_done_nxt   = 1'b0;
            ret_nxt       = S_BURST;
            state_nxt     = S_EMIT;
          end
        end else if (kind_r != KIND_START) begin
          state_nxt = S_CREDIT;
          if (kind_r == KIND_TIMEOUT) begin
            scan_p_nxt     = sp_r;
            scan_cnt_nxt   = '0;
            scan_burst_nxt = 1'b0;
            state_nxt      = S_SCAN_RD;
          end else if (kind_r == KIND_ACK) begin
            if (idx_r <= lf_r) begin
              state_nxt = S_ACK_RD;
            end
          end else if (kind_r == KIND_NACK) begin
            if (idx_r <= lf_r) begin
              em_idx_nxt  = idx_r;
              em_done_nxt = 1'b0;
              ret_nxt     = S_CREDIT;
              state_nxt   = S_EMIT;
            end
          end
        end
      end
      S_ACK_RD: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = AW'(idx_r);
        state_nxt   = S_ACK_CHK;
      end
      S_ACK_CHK: begin
        mem_wr_addr = AW'(idx_r);
        mem_wr_data = 1'b1;
        if (!mem_rd_data) begin
          mem_wr_en     = 1'b1;
          ack_total_nxt = ack_total_r + 1'b1;
        end
        state_nxt = S_CREDIT;
      end
      S_CREDIT: begin
        credit_nxt = credit_inc;
        state_nxt  = S_BURST;
      end
      S_BURST: begin
        if (credit_r != '0 && ack_total_r <= {1'b0, lf_r} && res_room) begin
          scan_p_nxt     = sp_r;
          scan_cnt_nxt   = '0;
          scan_burst_nxt = 1'b1;
          state_nxt      = S_SCAN_RD;
        end else begin
          state_nxt = S_TAIL;
        end
      end
      S_SCAN_RD: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = AW'(p_next);
        scan_p_nxt  = p_next;
        state_nxt   = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (!mem_rd_data) begin
          sp_nxt      = scan_p_r;
          em_idx_nxt  = scan_p_r;
          em_done_nxt = 1'b0;
          state_nxt   = S_EMIT;
          if (scan_burst_r) begin
            credit_nxt = credit_r - 1'b1;
            ret_nxt    = S_BURST;
          end else begin
            ret_nxt = S_CREDIT;
          end
        end else if (scan_cnt_r == lf_r) begin
          // every frame acknowledged, nothing to send
          if (scan_burst_r) begin
            credit_nxt = '0;
            state_nxt  = S_TAIL;
          end else begin
            state_nxt = S_CREDIT;
          end
        end else begin
          scan_cnt_nxt = scan_cnt_r + 1'b1;
          state_nxt    = S_SCAN_RD;
        end
      end
      S_EMIT: begin
        emit_req.push = 1'b1;
        if (emit_ready) begin
          n_nxt     = n_r + 1'b1;
          state_nxt = ret_r;
        end
      end
      S_TAIL: begin
        credit_nxt = credit_inc;
        state_nxt  = S_FLUSH;
        if (ack_total_r >= {1'b0, lf_r} + 1'b1) begin
          phase_nxt = PH_DONE;
          if (res_room) begin
            em_idx_nxt  = '0;
            em_done_nxt = 1'b1;
            ret_nxt     = S_FLUSH;
            state_nxt   = S_EMIT;
          end
        end
      end
      S_FLUSH: begin
        emit_req.flush = 1'b1;
        if (emit_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      ret_r        <= S_FLUSH;
      phase_r      <= PH_IDLE;
      clr_cnt_r    <= '0;
      sp_r         <= '0;
      credit_r     <= '0;
      ack_total_r  <= '0;
      n_r          <= '0;
      scan_burst_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      ret_r        <= ret_nxt;
      phase_r      <= phase_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      sp_r         <= sp_nxt;
      credit_r     <= credit_nxt;
      ack_total_r  <= ack_total_nxt;
      n_r          <= n_nxt;
      scan_burst_r <= scan_burst_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    idx_r      <= idx_nxt;
    lf_r       <= lf_nxt;
    scan_p_r   <= scan_p_nxt;
    scan_cnt_r <= scan_cnt_nxt;
    em_idx_r   <= em_idx_nxt;
    em_done_r  <= em_done_nxt;
  end

endmodule

@@ hdl/selective_repeat_arq_sender.sv @@
// top level of the selective repeat arq sender: config registers and wiring
// depends on srarq_pkg, srarq_if, srarq_mark_mem, srarq_out_stage, srarq_seq
//
// Channels: in_req carries protocol events (start, ack, nack, timeout,
// other reply) with a frame index; out_res returns frame numbers to send,
// a done flag once every frame is acknowledged, and last on the final
// result of each event; cfg_wr writes last_frame (index 0) and
// initial_window (index 1) and is always ready.
// After rst_n goes high the mark bitmap is cleared, one frame per cycle,
// over all MAX_FRAMES frames; in_req.ready stays low until that completes.
// One event is handled at a time, in steps: decode, an ack lookup,
// crediting, each burst step, a read and a check for each frame looked
// at by a scan (single bitmap read port), each result, and closing the
// event. Scans over long acknowledged runs read and check every skipped
// frame.
// Results wait in an output register plus one held entry; when out_res is
// stalled the sequencer stops until there is room, so nothing is lost.
module selective_repeat_arq_sender #(
  parameter int MAX_FRAMES = srarq_pkg::MAX_FRAMES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  srarq_in_if.sink     in_req,
  srarq_out_if.source  out_res,
  srarq_cfg_if.sink    cfg_wr
);
  import srarq_pkg::*;

  localparam int AW = $clog2(MAX_FRAMES);

  logic [FRAME_W-1:0] last_frame_r;
  logic [WIN_W-1:0]   init_window_r;
  logic               mem_rd_en;
  logic [AW-1:0]      mem_rd_addr;
  logic               mem_rd_data;
  logic               mem_wr_en;
  logic [AW-1:0]      mem_wr_addr;
  logic               mem_wr_data;
  emit_req_t          emit_req;
  logic               emit_ready;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_frame_r  <= FRAME_W'(1);
      init_window_r <= WIN_W'(1);
    end else if (cfg_wr.valid) begin
      case (cfg_wr.index)
        REG_LAST_FRAME:  last_frame_r  <= cfg_wr.data[FRAME_W-1:0];
        REG_INIT_WINDOW: init_window_r <= cfg_wr.data[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  srarq_mark_mem #(
    .DEPTH (MAX_FRAMES),
    .AW    (AW)
  ) u_marks (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  srarq_seq #(
    .MAX_FRAMES (MAX_FRAMES),
    .AW         (AW)
  ) u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_req.valid),
    .in_ready        (in_req.ready),
    .in_kind         (in_req.kind),
    .in_frame_index  (in_req.frame_index),
    .cfg_last_frame  (last_frame_r),
    .cfg_init_window (init_window_r),
    .mem_rd_en       (mem_rd_en),
    .mem_rd_addr     (mem_rd_addr),
    .mem_rd_data     (mem_rd_data),
    .mem_wr_en       (mem_wr_en),
    .mem_wr_addr     (mem_wr_addr),
    .mem_wr_data     (mem_wr_data),
    .emit_req        (emit_req),
    .emit_ready      (emit_ready)
  );

  srarq_out_stage u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .req            (emit_req),
    .req_ready      (emit_ready),
    .out_valid      (out_res.valid),
    .out_ready      (out_res.ready),
    .out_send_index (out_res.send_index),
    .out_done_res   (out_res.done_res),
    .out_last       (out_res.last)
  );

endmodule

@@ hdl/srarq_checker.sv @@
// port-level checks for the selective repeat arq sender, bound to the top
// depends on srarq_if and selective_repeat_arq_sender
module srarq_checker (
  input logic          clk,
  input logic          rst_n,
  srarq_in_if.sink     in_req,
  srarq_out_if.source  out_res
);

  logic seen_done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_done_r <= 1'b0;
    end else if (out_res.valid && out_res.ready && out_res.done_res) begin
      seen_done_r <= 1'b1;
    end
  end

  // clearing pass holds off requests right after reset
  a_reset_busy: assert property (@(posedge clk) !rst_n |=> !in_req.ready)
    else $error("input ready right after reset");

  // one request at a time: busy the cycle after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_req.valid && in_req.ready |=> !in_req.ready)
    else $error("input accepted twice in a row");

  // a done result carries frame 0 and closes its request
  a_done_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && out_res.done_res |-> out_res.last && out_res.send_index == '0)
    else $error("done result malformed");

  // once done, every later result is a done result
  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    seen_done_r && out_res.valid |-> out_res.done_res)
    else $error("send after done");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && !out_res.ready |=> out_res.valid && $stable(out_res.send_index))
    else $error("stalled result changed");

endmodule

bind selective_repeat_arq_sender srarq_checker u_chk (
  .clk     (clk),
  .rst_n   (rst_n),
  .in_req  (in_req),
  .out_res (out_res)
);
